// File: rtl/core/weekday_alarm_table_unit_macros.svh
// Assertion macros for the alarm table RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef WEEKDAY_ALARM_TABLE_UNIT_MACROS_SVH
`define WEEKDAY_ALARM_TABLE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define WAT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define WAT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define WAT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define WAT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/core/wat_pkg.sv
// Package for the weekday alarm table: entry layout, codes and constants.
// No dependencies; every RTL file but the assertion macros header imports it.
`default_nettype none
package wat_pkg;

  localparam int DEF_ALARM_SLOTS = 32;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_SNOOZE_MINUTES   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_DAY_MASK = 2'd1;

  localparam logic [5:0] SNOOZE_RESET   = 6'd5;
  localparam logic [6:0] DAY_MASK_RESET = 7'd127;
  localparam logic [5:0] MAX_SNOOZE     = 6'd59;
  localparam logic [6:0] MINUTES_PER_HR = 7'd60;
  localparam logic [4:0] LAST_HOUR      = 5'd23;
  localparam logic [4:0] HOURS_PER_DAY  = 5'd24;
  localparam logic [2:0] DAYS_PER_WEEK  = 3'd7;

  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_ADD     = 3'd1;
  localparam logic [2:0] CMD_DELETE  = 3'd2;
  localparam logic [2:0] CMD_TOGGLE  = 3'd3;
  localparam logic [2:0] CMD_SNOOZE  = 3'd4;
  localparam logic [2:0] CMD_DISMISS = 3'd5;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_FULL        = 3'd1;
  localparam logic [2:0] ST_BAD_TIME    = 3'd2;
  localparam logic [2:0] ST_BAD_INDEX   = 3'd3;
  localparam logic [2:0] ST_NOT_RINGING = 3'd4;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] mask;
    logic       active;
    logic       triggered;
  } wat_entry_t;

  // Result of evaluating one entry against a tick.
  typedef struct packed {
    wat_entry_t entry;
    logic       fire;
  } wat_eval_t;

endpackage
`default_nettype wire

// File: rtl/core/wat_channels.sv
// Valid/ready channel interfaces for the alarm table: request, response, config.
// Depends on wat_pkg for the configuration widths.
`default_nettype none
interface wat_req_if import wat_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [2:0] weekday;
  logic [4:0] entry_index;
  modport source (output valid, cmd, hour, minute, weekday, entry_index, input ready);
  modport sink (input valid, cmd, hour, minute, weekday, entry_index, output ready);
endinterface

interface wat_rsp_if import wat_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       ringing;
  logic [4:0] ring_index;
  logic       new_ring;
  logic [5:0] alarm_count;
  logic       entry_active;
  modport source (output valid, status, ringing, ring_index, new_ring, alarm_count,
                  entry_active, input ready);
  modport sink (input valid, status, ringing, ring_index, new_ring, alarm_count,
                entry_active, output ready);
endinterface

interface wat_cfg_if import wat_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/wat_mem.sv
// Alarm entry storage: one write port and one registered read port.
// Depends on wat_pkg for the entry layout.
`default_nettype none
module wat_mem import wat_pkg::*; #(
  parameter int DEPTH = DEF_ALARM_SLOTS
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire wat_entry_t                           wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output wat_entry_t                                rdata
);

  wat_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/wat_eval.sv
// Shared match unit: compares one stored entry with the tick time and weekday.
// Depends on wat_pkg for the entry and result types.
`default_nettype none
module wat_eval import wat_pkg::*; (
  input  wire wat_entry_t entry,
  input  wire logic [4:0] hour,
  input  wire logic [5:0] minute,
  input  wire logic [2:0] weekday,
  output wat_eval_t       result
);

  logic [6:0] day_bit;
  logic       same_time;
  logic       hit;

  always_comb begin
    day_bit   = (weekday < DAYS_PER_WEEK) ? (7'd1 << weekday) : 7'd0;
    same_time = (entry.hour == hour) && (entry.minute == minute);
    hit       = entry.active && ((entry.mask & day_bit) != 7'd0) && same_time;
    result.entry = entry;
    result.fire  = 1'b0;
    if (hit) begin
      // A matching entry fires only once until the time moves on.
      if (!entry.triggered) begin
        result.entry.triggered = 1'b1;
        result.fire = 1'b1;
      end
    end else if (!same_time) begin
      result.entry.triggered = 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/weekday_alarm_table_unit.sv
// Top level of the weekday alarm table: sequencer, state registers, channels.
// Depends on wat_pkg, wat_channels, wat_mem, wat_eval and the assertion macros.
`default_nettype none
`include "weekday_alarm_table_unit_macros.svh"

// The unit holds up to ALARM_SLOTS alarm entries in a single-port-write,
// registered-read memory and takes one request transaction at a time; req.ready
// is low while a request is being worked on. Add, snooze, dismiss and unused
// codes go straight to the final step. Toggle does one memory read, then one
// write back. A tick walks the held entries through the shared match unit at
// one entry per cycle once the first read is registered. A delete moves every
// later entry down one place, one entry per cycle. Each request produces
// exactly one response transaction; the response sits in an output register,
// and the sequencer holds in its final step until that register is free.
// Configuration transactions are always accepted and take effect at once;
// they are meant to be issued only while the unit is idle. Entries at or above
// the current count are never used, so the memory needs no clearing after reset.
module weekday_alarm_table_unit import wat_pkg::*; #(
  parameter int ALARM_SLOTS = DEF_ALARM_SLOTS
) (
  input  wire logic clk,
  input  wire logic rst,
  wat_cfg_if.sink   cfg,
  wat_req_if.sink   req,
  wat_rsp_if.source rsp
);

  localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int CNT_W = $clog2(ALARM_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(ALARM_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_TOGGLE,
    S_FINISH
  } state_t;

  state_t state;

  // Configuration registers.
  logic [5:0] snooze_minutes;
  logic [6:0] default_day_mask;

  // Architectural state.
  logic [CNT_W-1:0] count;
  logic             ring_flag;
  logic [4:0]       last_idx;

  // Captured request fields used by multi-cycle commands.
  logic [4:0]       hour_q;
  logic [5:0]       minute_q;
  logic [2:0]       weekday_q;
  logic [IDX_W-1:0] idx_q;

  // Walk pointers: rd_ptr is the next address to read, pend_addr the address
  // whose data appears at the memory output this cycle.
  logic [CNT_W-1:0] rd_ptr;
  logic [IDX_W-1:0] pend_addr;

  // Response fields being assembled.
  logic [2:0] status_q;
  logic       new_ring_q;
  logic       act_q;

  // Memory and match unit connections.
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  wat_entry_t       mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  wat_entry_t       mem_rdata;
  wat_eval_t        eval;

  // Decode of the incoming request, used in the idle state, plus toggle and response helpers.
  logic             accept;
  logic             full;
  logic             idx_ok;
  logic             add_time_ok;
  logic             snz_time_ok;
  logic [5:0]       snz_add;
  logic [6:0]       snz_sum;
  logic [5:0]       snz_minute;
  logic [4:0]       snz_hour;
  logic [CNT_W-1:0] req_idx;
  logic             rsp_free;
  wat_entry_t       new_entry;
  wat_entry_t       toggled;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign accept    = req.valid && req.ready;
  assign rsp_free  = !rsp.valid || rsp.ready;

  always_comb begin
    full        = (count >= SLOTS_C);
    idx_ok      = ({2'b00, req.entry_index} < 7'(count));
    req_idx     = CNT_W'(req.entry_index);
    add_time_ok = (req.hour < HOURS_PER_DAY) && ({1'b0, req.minute} < MINUTES_PER_HR);
    snz_time_ok = add_time_ok && (req.weekday < DAYS_PER_WEEK);
    // The snooze amount is clamped to 59 minutes.
    snz_add     = (snooze_minutes > MAX_SNOOZE) ? MAX_SNOOZE : snooze_minutes;
    snz_sum     = {1'b0, req.minute} + {1'b0, snz_add};
    if (snz_sum >= MINUTES_PER_HR) begin
      snz_minute = 6'(snz_sum - MINUTES_PER_HR);
      snz_hour   = (req.hour == LAST_HOUR) ? 5'd0 : req.hour + 5'd1;
    end else begin
      snz_minute = snz_sum[5:0];
      snz_hour   = req.hour;
    end
    new_entry           = '0;
    new_entry.active    = 1'b1;
    new_entry.triggered = 1'b0;
    if (req.cmd == CMD_SNOOZE) begin
      new_entry.hour   = snz_hour;
      new_entry.minute = snz_minute;
      new_entry.mask   = 7'd1 << req.weekday;
    end else begin
      new_entry.hour   = req.hour;
      new_entry.minute = req.minute;
      new_entry.mask   = default_day_mask;
    end
    toggled           = mem_rdata;
    toggled.active    = !mem_rdata.active;
    toggled.triggered = 1'b0;
  end

  // Memory port steering. During a tick or delete walk, reads run ahead of the
  // write-back, so the two ports never address the same entry in one cycle.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_addr;
    mem_wdata = eval.entry;
    mem_raddr = rd_ptr[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        mem_waddr = count[IDX_W-1:0];
        mem_wdata = new_entry;
        case (req.cmd)
          CMD_TICK:   mem_raddr = '0;
          CMD_DELETE: mem_raddr = IDX_W'(req_idx + CNT_W'(1));
          default:    mem_raddr = IDX_W'(req_idx);
        endcase
        if (accept && !full) begin
          mem_we = (req.cmd == CMD_ADD && add_time_ok) ||
                   (req.cmd == CMD_SNOOZE && ring_flag && snz_time_ok);
        end
      end
      S_SCAN: begin
        mem_we = 1'b1;
      end
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = pend_addr - IDX_W'(1);
        mem_wdata = mem_rdata;
      end
      S_TOGGLE: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = toggled;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  wat_mem #(
    .DEPTH (ALARM_SLOTS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  wat_eval u_eval (
    .entry   (mem_rdata),
    .hour    (hour_q),
    .minute  (minute_q),
    .weekday (weekday_q),
    .result  (eval)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      snooze_minutes   <= SNOOZE_RESET;
      default_day_mask <= DAY_MASK_RESET;
      count            <= '0;
      ring_flag        <= 1'b0;
      last_idx         <= '0;
      rsp.valid        <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_SNOOZE_MINUTES:   snooze_minutes   <= cfg.data[5:0];
          REG_DEFAULT_DAY_MASK: default_day_mask <= cfg.data[6:0];
          default: ;
        endcase
      end

      // A response taken at this edge frees the output register, unless the
      // final step loads the next response into it in the same cycle.
      if (rsp.valid && rsp.ready && state != S_FINISH) begin
        rsp.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            hour_q     <= req.hour;
            minute_q   <= req.minute;
            weekday_q  <= req.weekday;
            idx_q      <= IDX_W'(req_idx);
            new_ring_q <= 1'b0;
            act_q      <= 1'b0;
            case (req.cmd)
              CMD_TICK: begin
                status_q <= ST_OK;
                if (count != '0) begin
                  pend_addr <= '0;
                  rd_ptr    <= CNT_W'(1);
                  state     <= S_SCAN;
                end else begin
                  state <= S_FINISH;
                end
              end
              CMD_ADD: begin
                state <= S_FINISH;
                if (full) begin
                  status_q <= ST_FULL;
                end else if (!add_time_ok) begin
                  status_q <= ST_BAD_TIME;
                end else begin
                  status_q <= ST_OK;
                  count    <= count + CNT_W'(1);
                end
              end
              CMD_DELETE: begin
                if (!idx_ok) begin
                  status_q <= ST_BAD_INDEX;
                  state    <= S_FINISH;
                end else if (req_idx + CNT_W'(1) < count) begin
                  status_q  <= ST_OK;
                  pend_addr <= IDX_W'(req_idx + CNT_W'(1));
                  rd_ptr    <= req_idx + CNT_W'(2);
                  state     <= S_SHIFT;
                end else begin
                  status_q <= ST_OK;
                  count    <= count - CNT_W'(1);
                  state    <= S_FINISH;
                end
              end
              CMD_TOGGLE: begin
                if (!idx_ok) begin
                  status_q <= ST_BAD_INDEX;
                  state    <= S_FINISH;
                end else begin
                  status_q <= ST_OK;
                  state    <= S_TOGGLE;
                end
              end
              CMD_SNOOZE: begin
                state <= S_FINISH;
                if (!ring_flag) begin
                  status_q <= ST_NOT_RINGING;
                end else if (full) begin
                  status_q <= ST_FULL;
                end else if (!snz_time_ok) begin
                  status_q <= ST_BAD_TIME;
                end else begin
                  status_q  <= ST_OK;
                  count     <= count + CNT_W'(1);
                  ring_flag <= 1'b0;
                end
              end
              CMD_DISMISS: begin
                status_q  <= ST_OK;
                ring_flag <= 1'b0;
                state     <= S_FINISH;
              end
              default: begin
                status_q <= ST_OK;
                state    <= S_FINISH;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (eval.fire) begin
            ring_flag  <= 1'b1;
            last_idx   <= 5'(pend_addr);
            new_ring_q <= 1'b1;
          end
          if (rd_ptr < count) begin
            pend_addr <= rd_ptr[IDX_W-1:0];
            rd_ptr    <= rd_ptr + CNT_W'(1);
          end else begin
            state <= S_FINISH;
          end
        end
        S_SHIFT: begin
          if (rd_ptr < count) begin
            pend_addr <= rd_ptr[IDX_W-1:0];
            rd_ptr    <= rd_ptr + CNT_W'(1);
          end else begin
            count <= count - CNT_W'(1);
            state <= S_FINISH;
          end
        end
        S_TOGGLE: begin
          act_q <= toggled.active;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (rsp_free) begin
            rsp.valid        <= 1'b1;
            rsp.status       <= status_q;
            rsp.ringing      <= ring_flag;
            rsp.ring_index   <= last_idx;
            rsp.new_ring     <= new_ring_q;
            rsp.alarm_count  <= 6'(count);
            rsp.entry_active <= act_q;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `WAT_ASSERT_NXT(a_busy_after_accept, clk, rst, accept, !req.ready,
                  "request accepted but unit still ready next cycle")
  `WAT_ASSERT_IMP(a_scan_in_range, clk, rst, state == S_SCAN, 7'(pend_addr) < 7'(count),
                  "tick walk reached an entry beyond the count")
  `WAT_ASSERT_NXT(a_delete_shrinks, clk, rst, state == S_SHIFT && !(rd_ptr < count),
                  count == $past(count) - CNT_W'(1),
                  "delete did not reduce the entry count by one")
  `WAT_ASSERT_IMP(a_new_ring_rings, clk, rst, rsp.valid && rsp.new_ring, rsp.ringing,
                  "new alarm reported without the ring flag set")

endmodule
`default_nettype wire
